FILE: rtl/dve_pkg.sv
// Package for the delta varint encoder: item structs and code constants.
// Used by the top, front and back modules of the encoder; depends on nothing else.
package dve_pkg;

  typedef struct packed {
    logic signed [63:0] value;
    logic               first_item;
  } in_item_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last_byte;
    logic [3:0] code_length;
  } out_item_t;

  localparam logic [7:0] END_FLAG   = 8'h80;
  localparam logic [7:0] NEG_FLAG   = 8'h40;
  localparam logic [5:0] LOW_MASK   = 6'h3F;
  localparam logic [6:0] GROUP_MASK = 7'h7F;
  localparam int         LOW_BITS   = 6;
  localparam int         GROUP_BITS = 7;
  localparam int         MAX_BYTES  = 10;
  localparam int         LEN_W      = 4;

endpackage

FILE: rtl/delta_varint_encoder_unit.sv
// Delta varint encoder. Each item (a signed value and a first-of-vector
// flag) becomes 1 to 10 code bytes, most significant group first, sent one
// byte per cycle, unless out_ready stalls, through a registered output. An
// item with an n-byte code holds the byte emitter for all of its bytes,
// so the byte emitter sets the item throughput. After the input accept
// edge the item enters the delta stage, then the two-entry queue, then the
// output register. Input items keep flowing into the front stage and
// queue while bytes drain.
// Depends on dve_pkg, dve_front, dve_queue and dve_back.
module delta_varint_encoder_unit import dve_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int Q_W = VALUE_WIDTH + 1 + LEN_W;

  logic                   delta_mode_r, delta_mode_nxt;
  logic                   push_valid, push_ready;
  logic [VALUE_WIDTH-1:0] push_mag;
  logic                   push_neg;
  logic [LEN_W-1:0]       push_len;
  logic                   pop_valid, pop_ready;
  logic [Q_W-1:0]         pop_data;

  assign delta_mode_nxt = cfg_wr_en ? cfg_wr_data : delta_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delta_mode_r <= 1'b0;
    end else begin
      delta_mode_r <= delta_mode_nxt;
    end
  end

  dve_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .delta_mode (delta_mode_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_mag   (push_mag),
    .push_neg   (push_neg),
    .push_len   (push_len)
  );

  dve_queue #(.DATA_W(Q_W)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_mag, push_neg, push_len}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  dve_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_mag   (pop_data[Q_W-1 -: VALUE_WIDTH]),
    .pop_neg   (pop_data[LEN_W]),
    .pop_len   (pop_data[LEN_W-1:0]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef NO_ASSERTIONS
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.code_length >= 4'd1 && out_data.code_length <= 4'd10))
    else $error("code length out of range");

  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.code_length == 4'd1) |-> out_data.last_byte)
    else $error("one-byte code without last byte flag");

  a_lead_no_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_byte) |-> !out_data.code_byte[7])
    else $error("leading byte carries stop bit");

  a_code_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_byte) |=>
      (out_valid && out_data.code_length == $past(out_data.code_length)))
    else $error("code broken off before its last byte");
`endif

endmodule

FILE: rtl/dve_front.sv
// Front end of the delta varint encoder: takes items, applies the delta in
// delta mode, splits sign and magnitude, finds the code length. Uses dve_pkg.
module dve_front import dve_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   delta_mode,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   push_valid,
  input  logic                   push_ready,
  output logic [VALUE_WIDTH-1:0] push_mag,
  output logic                   push_neg,
  output logic [LEN_W-1:0]       push_len
);

  logic [VALUE_WIDTH-1:0] prev_r, prev_nxt;
  logic [VALUE_WIDTH-1:0] num_r, num_nxt;
  logic                   stg_valid_r, stg_valid_nxt;
  logic [VALUE_WIDTH-1:0] x;
  logic [VALUE_WIDTH-1:0] prev_sel;
  logic                   accept;
  logic [VALUE_WIDTH-1:0] mag;
  logic [63:0]            mag_ext;
  logic [LEN_W-1:0]       len;

  assign x        = in_data.value[VALUE_WIDTH-1:0];
  assign prev_sel = in_data.first_item ? '0 : prev_r;
  assign in_ready = !stg_valid_r || push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    prev_nxt      = prev_r;
    num_nxt       = num_r;
    stg_valid_nxt = stg_valid_r;
    if (accept) begin
      // The previous raw input is tracked in both modes.
      prev_nxt      = x;
      num_nxt       = delta_mode ? (x - prev_sel) : x;
      stg_valid_nxt = 1'b1;
    end else if (push_ready) begin
      stg_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r      <= '0;
      stg_valid_r <= 1'b0;
    end else begin
      prev_r      <= prev_nxt;
      stg_valid_r <= stg_valid_nxt;
    end
    num_r <= num_nxt;
  end

  // The most negative number negates to itself, which read unsigned is
  // the correct magnitude.
  assign push_neg = num_r[VALUE_WIDTH-1];
  assign mag      = push_neg ? (~num_r + 1'b1) : num_r;
  assign mag_ext  = 64'(mag);

  always_comb begin
    len = LEN_W'(1);
    for (int k = 0; k < MAX_BYTES - 1; k++) begin
      if ((mag_ext >> (LOW_BITS + GROUP_BITS * k)) != 64'd0) begin
        len = LEN_W'(k + 2);
      end
    end
  end

  assign push_valid = stg_valid_r;
  assign push_mag   = mag;
  assign push_len   = len;

endmodule

FILE: rtl/dve_queue.sv
// Two-entry queue between the front and back ends of the encoder.
// Stands alone; it depends on no other file.
module dve_queue #(
  parameter int DATA_W = 69
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/dve_back.sv
// Back end of the delta varint encoder: walks the queued magnitude one
// byte per cycle when not stalled, into the output register. Uses dve_pkg.
module dve_back import dve_pkg::*; #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   pop_valid,
  output logic                   pop_ready,
  input  logic [VALUE_WIDTH-1:0] pop_mag,
  input  logic                   pop_neg,
  input  logic [LEN_W-1:0]       pop_len,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  logic [LEN_W-1:0] grp_r, grp_nxt;
  logic [LEN_W-1:0] grp_cur;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  out_item_t        item;
  logic             load;
  logic [63:0]      mag_ext;
  logic [6:0]       grp_bits;

  // A zero group counter means the head entry has not been started yet.
  assign grp_cur   = (grp_r == '0) ? pop_len : grp_r;
  assign load      = pop_valid && (!out_valid_r || out_ready);
  assign pop_ready = load && (grp_cur == LEN_W'(1));
  assign mag_ext   = 64'(pop_mag);

  always_comb begin
    grp_bits = '0;
    for (int g = 2; g <= MAX_BYTES; g++) begin
      if (grp_cur == LEN_W'(g)) begin
        grp_bits = 7'(mag_ext >> (LOW_BITS + GROUP_BITS * (g - 2))) & GROUP_MASK;
      end
    end
  end

  always_comb begin
    item.code_length = pop_len;
    if (grp_cur == LEN_W'(1)) begin
      item.code_byte = END_FLAG | (pop_neg ? NEG_FLAG : 8'h00)
                       | {2'b00, pop_mag[5:0] & LOW_MASK};
      item.last_byte = 1'b1;
    end else begin
      item.code_byte = {1'b0, grp_bits};
      item.last_byte = 1'b0;
    end
  end

  always_comb begin
    grp_nxt       = grp_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      grp_nxt       = (grp_cur == LEN_W'(1)) ? '0 : grp_cur - 1'b1;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      grp_r       <= grp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_data_r <= item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: test/delta_varint_encoder_unit_tb.sv
// Self-checking testbench for delta_varint_encoder_unit: drives value items,
// predicts every code byte in the delta and direct modes and checks each one.
// Depends on dve_pkg and the delta_varint_encoder_unit RTL.
`timescale 1ns / 1ps

module delta_varint_encoder_unit_tb;
  import dve_pkg::*;

  localparam int VALUE_W = 64;
  localparam logic [63:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] BIT62 = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_wr_en = 1'b0;
  logic      cfg_wr_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  in_item_t  stim_items[$];
  out_item_t exp_bytes[$];

  // Shadow of the block state.
  logic [63:0] prev_raw = '0;
  logic        delta_on = 1'b0;

  int mismatches = 0;
  int items_taken = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  logic [63:0] gen_last = '0;

  delta_varint_encoder_unit #(.VALUE_WIDTH(VALUE_W)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  // Queues the code bytes that one accepted item must produce.
  function automatic void predict_code(in_item_t it);
    logic [63:0] base, num, mag, rest;
    logic        neg;
    int          len, g;
    out_item_t   b;
    base = it.first_item ? 64'd0 : prev_raw;
    num = delta_on ? it.value - base : it.value;
    prev_raw = it.value;
    neg = num[63];
    mag = neg ? -num : num;
    len = 1;
    if (mag > LOW_MASK) begin
      rest = mag >> LOW_BITS;
      len = 2;
      while (rest > GROUP_MASK && len < MAX_BYTES) begin
        rest = rest >> GROUP_BITS;
        len++;
      end
    end
    for (g = len; g >= 2; g--) begin
      rest = mag >> (LOW_BITS + GROUP_BITS * (g - 2));
      b.code_byte = {1'b0, rest[6:0]};
      b.last_byte = 1'b0;
      b.code_length = len[3:0];
      exp_bytes.push_back(b);
    end
    b.code_byte = END_FLAG | (neg ? NEG_FLAG : 8'h00) | {2'b00, mag[5:0]};
    b.last_byte = 1'b1;
    b.code_length = len[3:0];
    exp_bytes.push_back(b);
  endfunction

  // Sender: bursts of items separated by random gaps.
  always @(posedge clk) begin : sender
    logic     nv;
    in_item_t nd;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && in_ready) begin
        predict_code(in_data);
        items_taken <= items_taken + 1;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_items.size() > 0) begin
          nd = stim_items.pop_front();
          nv = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // Receiver: checks each code byte and stalls on its own pattern.
  always @(posedge clk) begin : receiver
    out_item_t want;
    logic      rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (exp_bytes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected code byte: byte=%h last=%b len=%0d",
                     out_data.code_byte, out_data.last_byte, out_data.code_length);
        end else begin
          want = exp_bytes.pop_front();
          if (out_data.code_byte !== want.code_byte || out_data.last_byte !== want.last_byte ||
              out_data.code_length !== want.code_length) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected byte=%h last=%b len=%0d, got byte=%h last=%b len=%0d",
                       want.code_byte, want.last_byte, want.code_length,
                       out_data.code_byte, out_data.last_byte, out_data.code_length);
          end
        end
      end
      // One long hold-off lets the encoder fill up and push back on its input.
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && items_taken >= 70) begin
        hold_done = 1;
        hold_left = 300;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   rdy = 1'b1;
          RX_HALF:   rdy = 1'($urandom_range(0, 1));
          RX_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      out_ready <= rdy;
    end
  end

  task automatic push_item(logic [63:0] v, logic f);
    in_item_t it;
    it.value = v;
    it.first_item = f;
    stim_items.push_back(it);
  endtask

  function automatic logic [63:0] rand_wide();
    logic [63:0] r;
    int          w;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0: return MAX_POS;
      1: return MIN_NEG;
      2, 3, 4: return r;
      default: begin
        w = $urandom_range(1, 63);
        r = r >> (64 - w);
        return $urandom_range(0, 1) ? -r : r;
      end
    endcase
  endfunction

  // Vectors of random length; many values sit close to the previous one so
  // that delta mode produces short codes as well as long ones.
  task automatic add_random(int n);
    int          added, vlen, i;
    logic [63:0] v;
    added = 0;
    while (added < n) begin
      vlen = $urandom_range(1, 12);
      for (i = 0; i < vlen && added < n; i++) begin
        if (i > 0 && $urandom_range(0, 1) == 0)
          v = gen_last + {{48{1'b0}}, 16'($urandom)} - 64'd32768;
        else
          v = rand_wide();
        push_item(v, (i == 0) || ($urandom_range(0, 15) == 0));
        gen_last = v;
        added++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (stim_items.size() != 0 || in_valid || exp_bytes.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_mode(logic m);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delta_on = m;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Direct mode after reset: byte-count boundaries and the extremes.
    push_item(64'd0, 1'b1);
    push_item(64'd1, 1'b0);
    push_item(-64'd1, 1'b0);
    push_item(64'd63, 1'b0);
    push_item(-64'd63, 1'b0);
    push_item(64'd64, 1'b1);
    push_item(-64'd64, 1'b0);
    push_item(64'd8191, 1'b0);
    push_item(64'd8192, 1'b0);
    push_item(BIT62 - 64'd1, 1'b0);
    push_item(BIT62, 1'b0);
    push_item(-BIT62, 1'b0);
    push_item(MAX_POS, 1'b0);
    push_item(MIN_NEG, 1'b0);
    wait_idle();

    // Delta mode: small steps, wrapping differences and the most negative delta.
    write_mode(1'b1);
    push_item(64'd5, 1'b1);
    push_item(64'd3, 1'b0);
    push_item(MAX_POS, 1'b0);
    push_item(MIN_NEG, 1'b0);
    push_item(MAX_POS, 1'b0);
    push_item(MIN_NEG, 1'b1);
    push_item(64'd0, 1'b0);
    push_item(64'h5555_5555_5555_5555, 1'b1);
    gen_last = 64'h5555_5555_5555_5555;
    add_random(70);
    wait_idle();

    write_mode(1'b0);
    add_random(75);
    wait_idle();

    write_mode(1'b1);
    add_random(75);
    wait_idle();

    repeat (20) @(posedge clk);
    if (mismatches == 0 && exp_bytes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
